// ----- design/rgb_to_cielab_converter_assert.svh -----
// Assertion macros shared by the converter RTL.
`ifndef RGB_TO_CIELAB_CONVERTER_ASSERT_SVH
`define RGB_TO_CIELAB_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
// Implication in the same cycle, inactive while in reset.
`define RGBL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication in the next cycle, checked through reset as well.
`define RGBL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RGBL_ASSERT_NOW(label, ante, cons)
`define RGBL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- design/rgbl_pkg.sv -----
// Shared constants for the RGB to CIE L*a*b* pipeline.
`default_nettype none
package rgbl_pkg;
  // Fractional bits of the L*a*b* outputs
  localparam int FRAC_BITS_DEF = 8;

  // Matrix coefficients times 10000
  localparam logic [13:0] CX_R = 14'd4124;
  localparam logic [13:0] CX_G = 14'd3576;
  localparam logic [13:0] CX_B = 14'd1805;
  localparam logic [13:0] CY_R = 14'd2126;
  localparam logic [13:0] CY_G = 14'd7152;
  localparam logic [13:0] CY_B = 14'd722;
  localparam logic [13:0] CZ_R = 14'd193;
  localparam logic [13:0] CZ_G = 14'd1192;
  localparam logic [13:0] CZ_B = 14'd9505;

  // White-point scaling: t = round(sum * MUL / DEN)
  localparam longint unsigned MUL_X = 64'd10 << 24;
  localparam longint unsigned DEN_X = 64'd255 * 64'd95047;
  localparam longint unsigned MUL_Y = 64'd1 << 24;
  localparam longint unsigned DEN_Y = 64'd255 * 64'd10000;
  localparam longint unsigned MUL_Z = 64'd100 << 24;
  localparam longint unsigned DEN_Z = 64'd255 * 64'd1088969;

  localparam int SUM_W = 22;   // row sum width
  localparam int T_W   = 25;   // normalised value, Q24
  localparam int F_W   = 21;   // f(t), Q20
  localparam int TL_W  = 18;   // low bits of t used by the linear segment

  localparam logic [T_W-1:0] THRESH_Q24 = 25'd148579;
  localparam logic [F_W-1:0] OFFSET_Q20 = 21'd144631;

  // Reciprocals: n/16000 = ((n>>7)*LIN_K)>>31, n/10 = (n*L_K)>>34
  localparam logic [24:0] LIN_K = 25'd17179870;
  localparam logic [30:0] L_K   = 31'd1717986919;

  // Latency of the f(t) unit
  localparam int F_LAT = 22;
endpackage
`default_nettype wire

// ----- design/rgbl_wscale.sv -----
// Rounded scaling of one row sum to the white point, reciprocal with correction.
`default_nettype none
module rgbl_wscale #(
  parameter longint unsigned MUL = 64'd16777216,
  parameter longint unsigned DEN = 64'd2550000
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [rgbl_pkg::SUM_W-1:0] sum,
  output logic [rgbl_pkg::T_W-1:0]     t
);
  import rgbl_pkg::*;

  localparam longint unsigned KR = (MUL << 24) / DEN;
  localparam logic [26:0] KR_V   = 27'(KR);
  localparam logic [30:0] MUL_V  = 31'(MUL);
  localparam logic [28:0] DEN_V  = 29'(DEN);
  localparam logic [54:0] HALF_V = 55'(DEN / 2);

  logic [48:0]       est;
  logic [SUM_W-1:0]  sum1;
  logic [25:0]       qe;
  logic [SUM_W-1:0]  sum2;
  logic [25:0]       qe2;
  logic [54:0]       prod;
  logic [54:0]       num;
  logic signed [56:0] rem;

  // Estimate, then exact remainder, then one-step correction
  always_ff @(posedge clk) begin
    if (en) begin
      est  <= 49'(sum * KR_V);
      sum1 <= sum;
      qe   <= 26'((est + 49'(1 << 23)) >> 24);
      sum2 <= sum1;
      prod <= 55'(qe * DEN_V);
      num  <= 55'(sum2 * MUL_V) + HALF_V;
      qe2  <= qe;
      if (rem < 0) begin
        t <= T_W'(qe2 - 26'd1);
      end else if (rem >= $signed({28'b0, DEN_V})) begin
        t <= T_W'(qe2 + 26'd1);
      end else begin
        t <= T_W'(qe2);
      end
    end
  end

  assign rem = $signed({2'b0, num}) - $signed({2'b0, prod});
endmodule
`default_nettype wire

// ----- design/rgbl_fq20.sv -----
// f(t) unit: bit-per-stage cube root beside the linear segment, Q24 in, Q20 out.
`default_nettype none
module rgbl_fq20 (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [rgbl_pkg::T_W-1:0] t,
  output logic [rgbl_pkg::F_W-1:0]     f,
  output logic                         above
);
  import rgbl_pkg::*;

  localparam int NB = F_W;   // root bits, one stage each

  logic [F_W-1:0] cr  [0:NB-1];
  logic [41:0]    cr2 [0:NB-2];
  logic [62:0]    cr3 [0:NB-2];
  logic [T_W-1:0] ct  [0:NB-2];

  logic [30:0]    lin1;
  logic [48:0]    lin2;
  logic [F_W-1:0] lind [0:NB-3];
  logic           ab   [0:NB-1];

  // Cube root: try each bit from the top, keep r, r^2 and r^3 up to date
  genvar i;
  for (i = 0; i < NB; i++) begin : g_root
    localparam int B = NB - 1 - i;
    logic [F_W-1:0] r_in;
    logic [41:0]    r2_in;
    logic [62:0]    r3_in;
    logic [T_W-1:0] t_in;
    logic [63:0]    rw;
    logic [63:0]    r2w;
    logic [63:0]    c2;
    logic [63:0]    c3;
    logic           fit;

    if (i == 0) begin : g_first
      assign r_in  = '0;
      assign r2_in = '0;
      assign r3_in = '0;
      assign t_in  = t;
    end else begin : g_next
      assign r_in  = cr[i-1];
      assign r2_in = cr2[i-1];
      assign r3_in = cr3[i-1];
      assign t_in  = ct[i-1];
    end

    assign rw  = 64'(r_in);
    assign r2w = 64'(r2_in);
    assign c2  = r2w + (rw << (B + 1)) + (64'd1 << (2 * B));
    assign c3  = 64'(r3_in) + ((r2w * 64'd3) << B) + ((rw * 64'd3) << (2 * B))
                 + (64'd1 << (3 * B));
    assign fit = c3 <= {3'b0, t_in, 36'b0};

    always_ff @(posedge clk) begin
      if (en) begin
        cr[i] <= fit ? (r_in | (F_W'(1) << B)) : r_in;
      end
    end

    if (i < NB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          cr2[i] <= fit ? c2[41:0] : r2_in;
          cr3[i] <= fit ? c3[62:0] : r3_in;
          ct[i]  <= t_in;
        end
      end
    end
  end

  // Linear segment and threshold flag, delayed to meet the root
  always_ff @(posedge clk) begin
    if (en) begin
      lin1    <= 31'(t[TL_W-1:0] * 13'd7787) + 31'd8000;
      lin2    <= 49'(lin1[30:7] * LIN_K);
      lind[0] <= F_W'(lin2 >> 31) + OFFSET_Q20;
      for (int k = 1; k < NB - 2; k++) begin
        lind[k] <= lind[k-1];
      end
      ab[0] <= t > THRESH_Q24;
      for (int k = 1; k < NB; k++) begin
        ab[k] <= ab[k-1];
      end
      f     <= ab[NB-1] ? cr[NB-1] : lind[NB-3];
      above <= ab[NB-1];
    end
  end
endmodule
`default_nettype wire

// ----- design/rgbl_lab.sv -----
// L*, a* and b* from f values: scale, round and saturate into the output register.
`default_nettype none
module rgbl_lab #(
  parameter int FRAC_BITS = rgbl_pkg::FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [rgbl_pkg::F_W-1:0]  fx,
  input  wire logic [rgbl_pkg::F_W-1:0]  fy,
  input  wire logic [rgbl_pkg::F_W-1:0]  fz,
  input  wire logic                     above_y,
  input  wire logic [rgbl_pkg::TL_W-1:0] ty,
  output logic [14:0]                   lightness,
  output logic [15:0]                   green_red_axis,
  output logic [15:0]                   blue_yellow_axis
);
  import rgbl_pkg::*;

  localparam int S1 = 20 - FRAC_BITS;
  localparam int S2 = 24 - FRAC_BITS;
  localparam int H1 = 1 << (S1 - 1);
  localparam int H2 = 1 << (S2 - 1);

  logic [31:0]        nl;
  logic signed [28:0] cubel;
  logic signed [21:0] da;
  logic signed [21:0] db;
  logic               ab1;
  logic [28:0]        ql;
  logic signed [28:0] cubel2;
  logic signed [30:0] av;
  logic signed [30:0] bv;
  logic               ab2;
  logic signed [31:0] l_cube;
  logic signed [31:0] l_lin;
  logic signed [31:0] a_r;
  logic signed [31:0] b_r;

  function automatic logic signed [31:0] sat(input logic signed [31:0] v,
                                             input logic signed [31:0] lo,
                                             input logic signed [31:0] hi);
    logic signed [31:0] res;
    res = v;
    if (v < lo) res = lo;
    if (v > hi) res = hi;
    return res;
  endfunction

  // Round to nearest, ties up: add half then shift toward minus infinity
  assign l_cube = (32'(cubel2) + 32'(H1)) >>> S1;
  assign l_lin  = ($signed({3'b0, ql}) + 32'(H2)) >>> S2;
  assign a_r    = (32'(av) + 32'(H1)) >>> S1;
  assign b_r    = (32'(bv) + 32'(H1)) >>> S1;

  always_ff @(posedge clk) begin
    if (en) begin
      // products and differences
      nl     <= 32'(ty * 14'd9033);
      cubel  <= $signed(29'({8'b0, fy} * 29'd116)) - 29'sd16777216;
      da     <= $signed({1'b0, fx}) - $signed({1'b0, fy});
      db     <= $signed({1'b0, fy}) - $signed({1'b0, fz});
      ab1    <= above_y;
      // divide by ten, scale the axes
      ql     <= 29'((64'(nl) * 64'(L_K)) >> 34);
      cubel2 <= cubel;
      av     <= 31'(32'(da) * 32'sd500);
      bv     <= 31'(32'(db) * 32'sd200);
      ab2    <= ab1;
      // select, saturate and register the result
      lightness        <= 15'(sat(ab2 ? l_cube : l_lin, 32'sd0, 32'sd32767));
      green_red_axis   <= 16'(sat(a_r, -32'sd32768, 32'sd32767));
      blue_yellow_axis <= 16'(sat(b_r, -32'sd32768, 32'sd32767));
    end
  end
endmodule
`default_nettype wire

// ----- design/rgb_to_cielab_converter.sv -----
// RGB to CIE L*a*b* converter, one pixel per beat through a stalling pipeline.
// Most of the path from an accepted beat to its result is the 21-stage cube root.
// Throughput: one pixel per cycle; the whole pipeline holds while a result waits.
// Reset (rst, synchronous, active high) clears the valid bits; data registers keep no reset.
`default_nettype none
module rgb_to_cielab_converter #(
  parameter int FRAC_BITS = rgbl_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  wire logic        s_tlast,   // end_of_frame
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // lightness[14:0], green_red_axis[30:15],
                                      // blue_yellow_axis[46:31], zero pad[47]
  output logic             m_tlast    // frame_done
);
  import rgbl_pkg::*;

  localparam int LAT  = 1 + 4 + F_LAT + 3;
  localparam int LMAX = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);

  logic                 en;
  logic                 vld [0:LAT-1];
  logic                 eof [0:LAT-1];
  logic [SUM_W-1:0]     xs;
  logic [SUM_W-1:0]     ys;
  logic [SUM_W-1:0]     zs;
  logic [T_W-1:0]       xq;
  logic [T_W-1:0]       yq;
  logic [T_W-1:0]       zq;
  logic [F_W-1:0]       fx;
  logic [F_W-1:0]       fy;
  logic [F_W-1:0]       fz;
  logic                 above_y;
  logic [TL_W-1:0]      yd [0:F_LAT-1];
  logic [14:0]          lightness;
  logic [15:0]          green_red_axis;
  logic [15:0]          blue_yellow_axis;

  // Advance everything unless a result is held at the output
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Valid bits and frame flag travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int k = 1; k < LAT; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eof[0] <= s_tlast;
      for (int k = 1; k < LAT; k++) eof[k] <= eof[k-1];
    end
  end

  // Matrix row sums
  always_ff @(posedge clk) begin
    if (en) begin
      xs <= SUM_W'(CX_R * SUM_W'(s_tdata[7:0]) + CX_G * SUM_W'(s_tdata[15:8])
                   + CX_B * SUM_W'(s_tdata[23:16]));
      ys <= SUM_W'(CY_R * SUM_W'(s_tdata[7:0]) + CY_G * SUM_W'(s_tdata[15:8])
                   + CY_B * SUM_W'(s_tdata[23:16]));
      zs <= SUM_W'(CZ_R * SUM_W'(s_tdata[7:0]) + CZ_G * SUM_W'(s_tdata[15:8])
                   + CZ_B * SUM_W'(s_tdata[23:16]));
    end
  end

  rgbl_wscale #(.MUL(MUL_X), .DEN(DEN_X)) u_scale_x (.clk, .en, .sum(xs), .t(xq));
  rgbl_wscale #(.MUL(MUL_Y), .DEN(DEN_Y)) u_scale_y (.clk, .en, .sum(ys), .t(yq));
  rgbl_wscale #(.MUL(MUL_Z), .DEN(DEN_Z)) u_scale_z (.clk, .en, .sum(zs), .t(zq));

  rgbl_fq20 u_f_x (.clk, .en, .t(xq), .f(fx), .above());
  rgbl_fq20 u_f_y (.clk, .en, .t(yq), .f(fy), .above(above_y));
  rgbl_fq20 u_f_z (.clk, .en, .t(zq), .f(fz), .above());

  // Hold Y alongside the f unit for the linear lightness segment
  always_ff @(posedge clk) begin
    if (en) begin
      yd[0] <= yq[TL_W-1:0];
      for (int k = 1; k < F_LAT; k++) yd[k] <= yd[k-1];
    end
  end

  rgbl_lab #(.FRAC_BITS(FRAC_BITS)) u_lab (
    .clk, .en, .fx, .fy, .fz, .above_y, .ty(yd[F_LAT-1]),
    .lightness, .green_red_axis, .blue_yellow_axis
  );

  assign m_tvalid = vld[LAT-1];
  assign m_tlast  = eof[LAT-1];
  assign m_tdata  = {1'b0, blue_yellow_axis, green_red_axis, lightness};

`include "rgb_to_cielab_converter_assert.svh"
  `RGBL_ASSERT_NEXT(a_reset_empties, rst, !m_tvalid)
  `RGBL_ASSERT_NOW(a_stall_only_on_held, !s_tready, m_tvalid && !m_tready)
  `RGBL_ASSERT_NOW(a_lightness_range, m_tvalid, m_tdata[14:0] <= 15'(LMAX))
endmodule
`default_nettype wire
